// ===== design/tfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfcd_pkg
// Shared constants for the text frame change detector.
// ----------------------------------------------------------------------------
package tfcd_pkg;

    // Store size in characters; frames longer than this are overlength
    localparam int MAX_FRAME_CHARS = 4096;
    localparam int ADDR_W          = $clog2(MAX_FRAME_CHARS);
    // Counters must also hold MAX_FRAME_CHARS itself
    localparam int CNT_W           = $clog2(MAX_FRAME_CHARS + 1);

    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 16;
    localparam int THR_W     = 7;
    localparam int PCT_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    // Widest product: density pct times previous count
    localparam int PROD_W    = CNT_W + PCT_W;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [THR_W-1:0] THR_RESET = 7'd30;
    localparam logic [PCT_W-1:0] PCT_RESET = 10'd80;
    localparam logic [PROD_W-1:0] HUNDRED  = PROD_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIMILARITY_THRESHOLD = 1'b0,
        CFG_DENSITY_CHANGE       = 1'b1
    } t_cfg_idx;

endpackage

// ===== design/tfcd_ram.sv =====
// ----------------------------------------------------------------------------
// tfcd_ram
// Generic simple dual-port RAM, one write and one read port, registered
// read-first output.
// ----------------------------------------------------------------------------
module tfcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a same-address write shows up on the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/text_frame_change_detector_unit.sv =====
// ----------------------------------------------------------------------------
// text_frame_change_detector_unit
// Compares each character frame against the previous one held in a RAM and
// flags sudden changes and nonblank density changes at each frame end.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | sink      | i_valid / o_stall  | i_character, i_frame_end
//  out     | source    | o_valid / i_stall  | o_frame_index, o_sudden_change,
//          |           |                    | o_density_change, o_overlength
//  cfg     | sink      | i_cfg_we           | i_cfg_index, i_cfg_wdata
//
//  One character beat per cycle, sustained while the output is not stalled.
//  A flagged frame end passes through the RAM read, then the products, then
//  the compares into the output register before it appears on the output.
//  The store needs no clearing after reset: a read is only compared below the
//  previous frame's length, so only entries already written are ever compared.
//  The whole pipeline advances when the output register is empty or being
//  taken; a stall on the output holds every stage and stalls the input.
//
module text_frame_change_detector_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // character stream
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [tfcd_pkg::CHAR_W-1:0]      i_character,
    input  logic                             i_frame_end,
    // results
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tfcd_pkg::IDX_W-1:0]       o_frame_index,
    output logic                             o_sudden_change,
    output logic                             o_density_change,
    output logic                             o_overlength,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [tfcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfcd_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int CNT_W  = tfcd_pkg::CNT_W;
    localparam int PROD_W = tfcd_pkg::PROD_W;

    // ---------------------------------------------------------------- config
    logic [tfcd_pkg::THR_W-1:0] r_thr;
    logic [tfcd_pkg::PCT_W-1:0] r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tfcd_pkg::THR_RESET;
            r_pct <= tfcd_pkg::PCT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfcd_pkg::CFG_SIMILARITY_THRESHOLD: r_thr <= i_cfg_wdata[tfcd_pkg::THR_W-1:0];
                tfcd_pkg::CFG_DENSITY_CHANGE:       r_pct <= i_cfg_wdata[tfcd_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- flow control
    // Every stage moves together; the output register is the only place a
    // result can wait.
    logic r_out_valid;
    logic adv;
    logic accept;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // --------------------------------------------- stage 0: frame counters
    logic [CNT_W-1:0]           r_pos;
    logic [CNT_W-1:0]           r_nb;
    logic                       r_ovl;
    logic [CNT_W-1:0]           r_prev_len;
    logic [CNT_W-1:0]           r_prev_nb;
    logic                       r_prev_ovl;
    logic                       r_have_prev;
    logic [tfcd_pkg::IDX_W-1:0] r_frame_cnt;

    logic             stored;
    logic             nonblank;
    logic             elig;
    logic [CNT_W-1:0] n_pos;
    logic [CNT_W-1:0] n_nb;
    logic             n_ovl;

    assign stored   = (r_pos != CNT_W'(tfcd_pkg::MAX_FRAME_CHARS));
    assign nonblank = (i_character != tfcd_pkg::CHAR_SPACE) &&
                      (i_character != tfcd_pkg::CHAR_NEWLINE);
    assign elig     = r_have_prev && stored && (r_pos < r_prev_len);
    assign n_pos    = stored ? r_pos + CNT_W'(1) : r_pos;
    assign n_nb     = (stored && nonblank) ? r_nb + CNT_W'(1) : r_nb;
    assign n_ovl    = r_ovl || !stored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_nb        <= '0;
            r_ovl       <= 1'b0;
            r_prev_len  <= '0;
            r_prev_nb   <= '0;
            r_prev_ovl  <= 1'b0;
            r_have_prev <= 1'b0;
            r_frame_cnt <= '0;
        end else if (accept) begin
            if (i_frame_end) begin
                r_prev_len  <= n_pos;
                r_prev_nb   <= n_nb;
                r_prev_ovl  <= n_ovl;
                r_have_prev <= 1'b1;
                r_pos       <= '0;
                r_nb        <= '0;
                r_ovl       <= 1'b0;
                if (r_frame_cnt != '1) begin
                    r_frame_cnt <= r_frame_cnt + tfcd_pkg::IDX_W'(1);
                end
            end else begin
                r_pos <= n_pos;
                r_nb  <= n_nb;
                r_ovl <= n_ovl;
            end
        end
    end

    // Previous frame store: read the old byte and overwrite it in the same cycle
    logic [tfcd_pkg::CHAR_W-1:0] rd_char;

    tfcd_ram #(
        .WIDTH (tfcd_pkg::CHAR_W),
        .DEPTH (tfcd_pkg::MAX_FRAME_CHARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && stored),
        .i_waddr (r_pos[tfcd_pkg::ADDR_W-1:0]),
        .i_wdata (i_character),
        .i_re    (accept),
        .i_raddr (r_pos[tfcd_pkg::ADDR_W-1:0]),
        .o_rdata (rd_char)
    );

    // ------------------------------------------- stage 1: compare, snapshot
    logic                        r_s1_valid;
    logic [tfcd_pkg::CHAR_W-1:0] r_s1_char;
    logic                        r_s1_elig;
    logic                        r_s1_last;
    logic                        r_s1_have_prev;
    logic [CNT_W-1:0]            r_s1_len;
    logic [CNT_W-1:0]            r_s1_prev_len;
    logic [CNT_W-1:0]            r_s1_cur_nb;
    logic [CNT_W-1:0]            r_s1_prev_nb;
    logic                        r_s1_ovl;
    logic [tfcd_pkg::IDX_W-1:0]  r_s1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_char      <= i_character;
            r_s1_elig      <= elig;
            r_s1_last      <= i_frame_end;
            r_s1_have_prev <= r_have_prev;
            r_s1_len       <= n_pos;
            r_s1_prev_len  <= r_prev_len;
            r_s1_cur_nb    <= n_nb;
            r_s1_prev_nb   <= r_prev_nb;
            r_s1_ovl       <= n_ovl || r_prev_ovl;
            r_s1_idx       <= r_frame_cnt;
        end
    end

    // Match count trails the position counter by the RAM latency
    logic [CNT_W-1:0] r_match;
    logic             hit;
    logic [CNT_W-1:0] match_tot;
    logic [CNT_W-1:0] diff;

    assign hit       = r_s1_valid && r_s1_elig && (rd_char == r_s1_char);
    assign match_tot = hit ? r_match + CNT_W'(1) : r_match;
    assign diff      = (r_s1_cur_nb >= r_s1_prev_nb) ? r_s1_cur_nb - r_s1_prev_nb
                                                     : r_s1_prev_nb - r_s1_cur_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else if (adv && r_s1_valid) begin
            r_match <= r_s1_last ? '0 : match_tot;
        end
    end

    // --------------------------------------------------- stage 2: products
    logic                       r_s2_valid;
    logic                       r_s2_len_ne;
    logic                       r_s2_prev_nz;
    logic [PROD_W-1:0]          r_s2_match100;
    logic [PROD_W-1:0]          r_s2_thr_len;
    logic [PROD_W-1:0]          r_s2_diff100;
    logic [PROD_W-1:0]          r_s2_pct_prev;
    logic                       r_s2_ovl;
    logic [tfcd_pkg::IDX_W-1:0] r_s2_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_last && r_s1_have_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_len_ne   <= (r_s1_len != r_s1_prev_len);
            r_s2_prev_nz  <= (r_s1_prev_nb != '0);
            r_s2_match100 <= PROD_W'(match_tot) * tfcd_pkg::HUNDRED;
            r_s2_thr_len  <= PROD_W'(r_thr) * PROD_W'(r_s1_len);
            r_s2_diff100  <= PROD_W'(diff) * tfcd_pkg::HUNDRED;
            r_s2_pct_prev <= PROD_W'(r_pct) * PROD_W'(r_s1_prev_nb);
            r_s2_ovl      <= r_s1_ovl;
            r_s2_idx      <= r_s1_idx;
        end
    end

    // --------------------------------------------- stage 3: output register
    logic sudden;
    logic dens;

    assign sudden = r_s2_len_ne || (r_s2_match100 < r_s2_thr_len);
    assign dens   = r_s2_prev_nz && (r_s2_diff100 > r_s2_pct_prev);

    logic                       r_out_sudden;
    logic                       r_out_dens;
    logic                       r_out_ovl;
    logic [tfcd_pkg::IDX_W-1:0] r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && (sudden || dens);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sudden <= sudden;
            r_out_dens   <= dens;
            r_out_ovl    <= r_s2_ovl;
            r_out_idx    <= r_s2_idx;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_index    = r_out_idx;
    assign o_sudden_change  = r_out_sudden;
    assign o_density_change = r_out_dens;
    assign o_overlength     = r_out_ovl;

    // ----------------------------------------------------------- assertions
    a_flag_set : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sudden_change || o_density_change))
        else $error("result beat with no flag set");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CNT_W'(tfcd_pkg::MAX_FRAME_CHARS))
        else $error("position counter beyond store size");

    a_frame_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_end) |=> (r_pos == '0 && r_nb == '0 && !r_ovl))
        else $error("frame counters not cleared after last beat");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_match_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && r_s1_last) |=> (r_match == '0))
        else $error("match count not cleared at frame end");

endmodule

// ===== tb/text_frame_change_detector_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_frame_change_detector_unit_tb
// Self-checking bench for the text frame change detector. Character beats are
// fed through the valid/stall input, a local model of the detector tracks the
// previous frame and its counters, and every flagged frame end it predicts is
// matched in order against the beats leaving the result channel.
// ----------------------------------------------------------------------------
module text_frame_change_detector_unit_tb;

    localparam int CLK_PERIOD   = 10;
    // three pipeline stages after the last beat, plus margin
    localparam int DRAIN_CYCLES = 8;
    // cycles with no beat moving on any channel before the run is abandoned
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BEATS = 240;

    typedef struct packed {
        logic [tfcd_pkg::IDX_W-1:0] frame_index;
        logic                       sudden_change;
        logic                       density_change;
        logic                       overlength;
    } t_frame_flags;

    // ------------------------------------------------------------------
    // DUT connections, every input driven to a known value from time zero
    // ------------------------------------------------------------------
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    logic [tfcd_pkg::CHAR_W-1:0]    i_character = '0;
    logic                           i_frame_end = 1'b0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    logic [tfcd_pkg::IDX_W-1:0]     o_frame_index;
    logic                           o_sudden_change;
    logic                           o_density_change;
    logic                           o_overlength;
    logic                           i_cfg_we    = 1'b0;
    logic [tfcd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [tfcd_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    text_frame_change_detector_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_character      (i_character),
        .i_frame_end      (i_frame_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_index    (o_frame_index),
        .o_sudden_change  (o_sudden_change),
        .o_density_change (o_density_change),
        .o_overlength     (o_overlength),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Detector model: copy of last frame plus running counters
    // ------------------------------------------------------------------
    logic [tfcd_pkg::CHAR_W-1:0] prev_store [tfcd_pkg::MAX_FRAME_CHARS];
    int                          prev_len      = 0;
    int                          prev_nonblank = 0;
    bit                          prev_over     = 1'b0;
    int                          cur_pos       = 0;
    int                          cur_matches   = 0;
    int                          cur_nonblank  = 0;
    bit                          cur_over      = 1'b0;
    int                          frame_no      = 0;
    bit                          have_prev     = 1'b0;
    logic [tfcd_pkg::THR_W-1:0]  sim_thr       = tfcd_pkg::THR_RESET;
    logic [tfcd_pkg::PCT_W-1:0]  dens_pct      = tfcd_pkg::PCT_RESET;

    // flagged frame ends still owed by the DUT, oldest first
    t_frame_flags                flagged_frames [$];

    // bench bookkeeping
    int                          n_beats   = 0;
    int                          n_results = 0;
    int                          n_errors  = 0;
    int                          idle_run  = 0;
    int                          send_idle_pct = 0;
    int                          stall_pct     = 0;
    int                          hold_left     = 0;
    logic [tfcd_pkg::CHAR_W-1:0] last_frame [$];

    // Advance the model by one accepted character; a flagged frame end
    // queues its expected result.
    function automatic void track_frame_char(logic [tfcd_pkg::CHAR_W-1:0] ch, logic last);
        t_frame_flags flags;
        bit           sudden;
        bit           dens;
        int           diff;
        if (cur_pos < tfcd_pkg::MAX_FRAME_CHARS) begin
            // only positions below the old length are compared, so unwritten
            // store entries are never looked at
            if (have_prev && cur_pos < prev_len && prev_store[cur_pos] == ch)
                cur_matches++;
            if (ch != tfcd_pkg::CHAR_SPACE && ch != tfcd_pkg::CHAR_NEWLINE)
                cur_nonblank++;
            prev_store[cur_pos] = ch;
            cur_pos++;
        end else begin
            // past the store: nothing counted, just remember it ran over
            cur_over = 1'b1;
        end

        if (last) begin
            if (have_prev) begin
                sudden = (cur_pos != prev_len) ||
                         (cur_matches * 100 < int'(sim_thr) * cur_pos);
                dens = 1'b0;
                if (prev_nonblank > 0) begin
                    diff = (cur_nonblank > prev_nonblank) ? cur_nonblank - prev_nonblank
                                                          : prev_nonblank - cur_nonblank;
                    dens = diff * 100 > int'(dens_pct) * prev_nonblank;
                end
                if (sudden || dens) begin
                    flags.frame_index    = frame_no[tfcd_pkg::IDX_W-1:0];
                    flags.sudden_change  = sudden;
                    flags.density_change = dens;
                    flags.overlength     = cur_over || prev_over;
                    flagged_frames       = {flagged_frames, flags};
                end
            end
            prev_len      = cur_pos;
            prev_nonblank = cur_nonblank;
            prev_over     = cur_over;
            have_prev     = 1'b1;
            cur_pos       = 0;
            cur_matches   = 0;
            cur_nonblank  = 0;
            cur_over      = 1'b0;
            if (frame_no < 32'hFFFF)
                frame_no++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: config writes, input beats, result checks and the watchdog.
    // Everything is sampled at the rising edge, before this edge's updates.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_frame_flags want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                moved = 1'b1;
                case (tfcd_pkg::t_cfg_idx'(i_cfg_index))
                    tfcd_pkg::CFG_SIMILARITY_THRESHOLD:
                        sim_thr  = i_cfg_wdata[tfcd_pkg::THR_W-1:0];
                    tfcd_pkg::CFG_DENSITY_CHANGE:
                        dens_pct = i_cfg_wdata[tfcd_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end

            if (i_valid && !o_stall) begin
                moved = 1'b1;
                n_beats++;
                track_frame_char(i_character, i_frame_end);
            end

            if (o_valid && !i_stall) begin
                moved = 1'b1;
                n_results++;
                if (flagged_frames.size() == 0) begin
                    $error("unexpected result beat: frame_index %0d", o_frame_index);
                    n_errors++;
                end else begin
                    want = flagged_frames.pop_front();
                    if (o_frame_index !== want.frame_index) begin
                        $error("frame_index: expected %0d, got %0d",
                               want.frame_index, o_frame_index);
                        n_errors++;
                    end
                    if (o_sudden_change !== want.sudden_change) begin
                        $error("sudden_change: expected %0b, got %0b",
                               want.sudden_change, o_sudden_change);
                        n_errors++;
                    end
                    if (o_density_change !== want.density_change) begin
                        $error("density_change: expected %0b, got %0b",
                               want.density_change, o_density_change);
                        n_errors++;
                    end
                    if (o_overlength !== want.overlength) begin
                        $error("overlength: expected %0b, got %0b",
                               want.overlength, o_overlength);
                        n_errors++;
                    end
                end
            end

            idle_run = moved ? 0 : idle_run + 1;
            if (idle_run >= STALL_LIMIT) begin
                $display("no beat moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, flagged_frames.size());
                $display("text_frame_change_detector_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin : receiver
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task is entered and left at a rising edge
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [tfcd_pkg::CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        i_frame_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [tfcd_pkg::CHAR_W-1:0] chars [$]);
        foreach (chars[k])
            send_beat(chars[k], k == chars.size() - 1);
        last_frame = chars;
    endtask

    // Wait until every predicted result is out, then let any frame end that
    // flags nothing clear the pipeline too.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (flagged_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int thr, input int pct);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tfcd_pkg::CFG_SIMILARITY_THRESHOLD;
        i_cfg_wdata <= tfcd_pkg::CFG_W'(thr);
        @(posedge i_clk);
        i_cfg_index <= tfcd_pkg::CFG_DENSITY_CHANGE;
        i_cfg_wdata <= tfcd_pkg::CFG_W'(pct);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Blanks at the given rate; otherwise mostly a tiny alphabet so edited
    // frames still match in places, sometimes any byte at all.
    function automatic logic [tfcd_pkg::CHAR_W-1:0] pick_char(int blank_pct);
        if ($urandom_range(0, 99) < blank_pct)
            return $urandom_range(0, 1) ? tfcd_pkg::CHAR_SPACE : tfcd_pkg::CHAR_NEWLINE;
        if ($urandom_range(0, 3) == 0)
            return tfcd_pkg::CHAR_W'($urandom_range(0, 255));
        return tfcd_pkg::CHAR_W'($urandom_range(8'h41, 8'h44));
    endfunction

    // Mostly an edited copy of the last frame (the interesting region for
    // both tests), sometimes one char longer or shorter, else a fresh frame.
    task automatic send_random_frame();
        logic [tfcd_pkg::CHAR_W-1:0] chars [$];
        int                          kind;
        int                          blank_pct;
        int                          edit_pct;
        int                          len;
        kind      = $urandom_range(0, 9);
        blank_pct = $urandom_range(0, 100);
        if (kind < 7 && last_frame.size() > 0 && last_frame.size() <= 200) begin
            chars    = last_frame;
            edit_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                   : $urandom_range(0, 20);
            foreach (chars[k])
                if ($urandom_range(0, 99) < edit_pct)
                    chars[k] = pick_char(blank_pct);
            if (kind == 5)
                chars = {chars, pick_char(blank_pct)};
            else if (kind == 6 && chars.size() > 1)
                void'(chars.pop_back());
        end else begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 200)
                                               : $urandom_range(1, 32);
            repeat (len) chars = {chars, pick_char(blank_pct)};
        end
        send_frame(chars);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: first frame silent, identical frame silent, length
    // change, blank-only frame, zero previous count, then the registers at
    // their widest values where every frame is a sudden change.
    task automatic test_directed();
        logic [tfcd_pkg::CHAR_W-1:0] chars [$];
        send_idle_pct = 36;
        stall_pct     = 62;
        chars = {8'h00, 8'hFF, tfcd_pkg::CHAR_SPACE, tfcd_pkg::CHAR_NEWLINE};
        send_frame(chars);
        send_frame(chars);
        chars = {8'h00, 8'hFF, tfcd_pkg::CHAR_SPACE};
        send_frame(chars);
        chars = {tfcd_pkg::CHAR_SPACE, tfcd_pkg::CHAR_NEWLINE, tfcd_pkg::CHAR_SPACE};
        send_frame(chars);
        chars = {8'h41, tfcd_pkg::CHAR_NEWLINE, tfcd_pkg::CHAR_SPACE};
        send_frame(chars);
        set_config(127, 1023);
        send_frame(chars);
    endtask

    task automatic test_random(input int idle, input int stall, input int thr,
                               input int pct);
        int start;
        set_config(thr, pct);
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = n_beats;
        while (n_beats - start < RANDOM_BEATS)
            send_random_frame();
    endtask

    // Result side held off for a long stretch while short, mostly flagged
    // frames keep coming: the pipeline fills and the input must stall.
    task automatic test_backpressure();
        logic [tfcd_pkg::CHAR_W-1:0] chars [$];
        set_config(100, 0);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        repeat (40) begin
            chars.delete();
            repeat (3) chars = {chars, pick_char(30)};
            send_frame(chars);
        end
    endtask

    initial begin : main
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(36, 62, 50, 25);
        test_random(62, 36, 100, 0);
        test_random(0, 0, 0, 1000);
        test_backpressure();

        wait_idle();
        $display("%0d character beats in %0d frames, %0d flagged results checked",
                 n_beats, frame_no, n_results);
        $display("reset and extreme settings, edited frames under three idle mixes, "
                 , "long output hold-off");
        if (n_errors == 0 && flagged_frames.size() == 0) begin
            $display("text_frame_change_detector_unit_tb: done, clean");
        end else begin
            $display("text_frame_change_detector_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
